### sv/lrcf_pkg.sv
// Shared types, constants and tables for the LED ring clock face renderer.
// No dependencies; every module of the block imports this package.
package lrcf_pkg;

	localparam int unsigned NUM_LEDS_DEF = 256;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned COLOR_W   = 24;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_BRIGHTNESS = 3'd0,
		REG_SEC_START      = 3'd1,
		REG_SEC_END        = 3'd2,
		REG_MIN_START      = 3'd3,
		REG_MIN_END        = 3'd4,
		REG_HOUR_START     = 3'd5,
		REG_HOUR_END       = 3'd6,
		REG_UNUSED         = 3'd7
	} cfg_reg_t;

	localparam logic [7:0] MAX_BRIGHTNESS_RST = 8'd31;

	typedef enum logic [1:0] {
		MODE_GREEN = 2'd0,
		MODE_RED   = 2'd1,
		MODE_BLUE  = 2'd2,
		MODE_CLOCK = 2'd3
	} mode_t;

	// what kind of pixel an item turned out to be
	typedef enum logic [2:0] {
		RGN_DARK     = 3'd0,
		RGN_FILL_G   = 3'd1,
		RGN_FILL_R   = 3'd2,
		RGN_FILL_B   = 3'd3,
		RGN_ARC_MIN  = 3'd4,
		RGN_ARC_SEC  = 3'd5,
		RGN_HOUR_CUR = 3'd6,
		RGN_HOUR_NXT = 3'd7
	} region_t;

	// x/60 == (x*17477)>>20 exactly for x < 23831; k*17477 fits in 21 bits for k <= 60
	localparam int unsigned RECIP_W     = 21;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam logic [RECIP_W-1:0] RECIP_60 = 21'd17477;
	// m*33/100 == (m*21627)>>16 for 8-bit m
	localparam logic [15:0] RECIP_33_100 = 16'd21627;

	localparam logic [7:0] ARC_END_LED   = 8'd120;
	localparam logic [7:0] SEC_ARC_LED   = 8'd60;
	localparam logic [5:0] TIME_MAX      = 6'd59;
	localparam logic [5:0] FULL_MINUTE   = 6'd60;
	localparam logic [5:0] ARC_OFFSET    = 6'd56;
	localparam logic [7:0] BRIGHT_FLOOR  = 8'd4;
	localparam logic [3:0] LAST_HOUR     = 4'd11;

	typedef struct packed {
		logic [7:0]         max_brightness;
		logic [COLOR_W-1:0] sec_start;
		logic [COLOR_W-1:0] sec_end;
		logic [COLOR_W-1:0] min_start;
		logic [COLOR_W-1:0] min_end;
		logic [COLOR_W-1:0] hour_start;
		logic [COLOR_W-1:0] hour_end;
	} cfg_regs_t;

	// decoded item held in the input register
	typedef struct packed {
		logic [7:0]         led;
		region_t            region;
		logic [7:0]         bri;
		logic [7:0]         cap;
		logic [RECIP_W-1:0] kmc;
		logic [RECIP_W-1:0] kmb;
	} dec_t;

	// hour segment boundaries
	function automatic logic [7:0] hour_bound(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'd120;
			4'd1:    b = 8'd136;
			4'd2:    b = 8'd141;
			4'd3:    b = 8'd152;
			4'd4:    b = 8'd162;
			4'd5:    b = 8'd170;
			4'd6:    b = 8'd181;
			4'd7:    b = 8'd193;
			4'd8:    b = 8'd200;
			4'd9:    b = 8'd213;
			4'd10:   b = 8'd223;
			4'd11:   b = 8'd240;
			4'd12:   b = 8'd250;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

### sv/lrcf_in_if.sv
// Input item channel: valid/ready plus the time, light and LED index fields.
// Stand-alone; no package needed.
interface lrcf_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  led_index;
	logic [5:0]  seconds;
	logic [5:0]  minutes;
	logic [4:0]  hours;
	logic [11:0] light_mv;

	modport source (output valid, led_index, seconds, minutes, hours, light_mv, input ready);
	modport sink   (input valid, led_index, seconds, minutes, hours, light_mv, output ready);
endinterface

### sv/lrcf_out_if.sv
// Result item channel: valid/ready plus the rendered pixel fields.
// Stand-alone; no package needed.
interface lrcf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] led_out_index;
	logic [7:0] brightness;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, led_out_index, brightness, red, green, blue, input ready);
	modport sink   (input valid, led_out_index, brightness, red, green, blue, output ready);
endinterface

### sv/lrcf_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Stand-alone; no package needed.
interface lrcf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### sv/lrcf_cfg_regs.sv
// Configuration register file, written through the config channel.
// Depends on lrcf_pkg and lrcf_cfg_if.
module lrcf_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	lrcf_cfg_if.sink          cfg,
	output lrcf_pkg::cfg_regs_t regs
);
	import lrcf_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{MAX_BRIGHTNESS_RST, '0, '0, '0, '0, '0, '0};
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_MAX_BRIGHTNESS: regs_q.max_brightness <= cfg.data[7:0];
				REG_SEC_START:      regs_q.sec_start      <= cfg.data;
				REG_SEC_END:        regs_q.sec_end        <= cfg.data;
				REG_MIN_START:      regs_q.min_start      <= cfg.data;
				REG_MIN_END:        regs_q.min_end        <= cfg.data;
				REG_HOUR_START:     regs_q.hour_start     <= cfg.data;
				REG_HOUR_END:       regs_q.hour_end       <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule

### sv/lrcf_decode.sv
// Item decode ahead of the input register: brightness cap, pixel region and
// blend factors (k scaled by the 1/60 reciprocal). Depends on lrcf_pkg.
module lrcf_decode #(
	parameter int unsigned NUM_LEDS = lrcf_pkg::NUM_LEDS_DEF
) (
	input  logic [7:0]         led_index,
	input  logic [5:0]         seconds,
	input  logic [5:0]         minutes,
	input  logic [4:0]         hours,
	input  logic [11:0]        light_mv,
	input  lrcf_pkg::mode_t    mode,
	input  logic [7:0]         max_brightness,
	output lrcf_pkg::dec_t     dec
);
	import lrcf_pkg::*;

	logic [23:0] cap33_prod;
	logic [9:0]  cap34_prod;
	logic [7:0]  cap_raw;
	logic [7:0]  cap;
	logic [5:0]  sec_s;
	logic [5:0]  min_s;
	logic [3:0]  hr;
	logic [7:0]  c0, c1, n0, n1;
	logic [6:0]  p_raw;
	logic [5:0]  p;
	logic [5:0]  v;
	logic        sec_arc;
	logic [5:0]  k_col;
	logic [5:0]  k_bri;

	always_comb begin
		cap33_prod = 24'(max_brightness) * 24'(RECIP_33_100);
		cap34_prod = 10'(max_brightness) * 10'd3;
		if (light_mv >= 12'd3000)      cap_raw = cap33_prod[23:16];
		else if (light_mv >= 12'd2000) cap_raw = max_brightness >> 1;
		else if (light_mv >= 12'd1000) cap_raw = cap34_prod[9:2];
		else                           cap_raw = max_brightness;
		cap = (cap_raw < BRIGHT_FLOOR) ? BRIGHT_FLOOR : cap_raw;

		sec_s = (seconds > TIME_MAX) ? TIME_MAX : seconds;
		min_s = (minutes > TIME_MAX) ? TIME_MAX : minutes;

		// hours mod 12 over the 5-bit range
		if (hours >= 5'd24)      hr = 4'(hours - 5'd24);
		else if (hours >= 5'd12) hr = 4'(hours - 5'd12);
		else                     hr = hours[3:0];

		c0 = hour_bound(hr);
		c1 = hour_bound(hr + 4'd1);
		n0 = (hr == LAST_HOUR) ? hour_bound(4'd0) : c1;
		n1 = (hr == LAST_HOUR) ? hour_bound(4'd1) : hour_bound(hr + 4'd2);

		// arc position (L-4) mod 60; the sum reaches 115, so it needs 7 bits
		sec_arc = led_index >= SEC_ARC_LED;
		p_raw = 7'(sec_arc ? led_index - SEC_ARC_LED : led_index) + 7'(ARC_OFFSET);
		p = (p_raw >= 7'(FULL_MINUTE)) ? 6'(p_raw - 7'(FULL_MINUTE)) : p_raw[5:0];
		v = sec_arc ? sec_s : min_s;

		dec.led    = led_index;
		dec.region = RGN_DARK;
		dec.bri    = '0;
		dec.cap    = cap;
		k_col      = '0;
		k_bri      = '0;

		if ({1'b0, led_index} < 9'(NUM_LEDS)) begin
			case (mode)
				MODE_GREEN: begin
					dec.region = RGN_FILL_G;
					dec.bri    = cap;
				end
				MODE_RED: begin
					dec.region = RGN_FILL_R;
					dec.bri    = cap >> 1;
				end
				MODE_BLUE: begin
					dec.region = RGN_FILL_B;
					dec.bri    = cap >> 2;
				end
				default: begin
					if (led_index < ARC_END_LED) begin
						if (p <= v) begin
							dec.region = sec_arc ? RGN_ARC_SEC : RGN_ARC_MIN;
							dec.bri    = cap;
							k_col      = v - p;
						end
					end else if (led_index >= c0 && led_index < c1) begin
						dec.region = RGN_HOUR_CUR;
						k_col      = min_s;
						k_bri      = FULL_MINUTE - min_s;
					end else if (led_index >= n0 && led_index < n1) begin
						dec.region = RGN_HOUR_NXT;
						k_col      = FULL_MINUTE - min_s;
						k_bri      = min_s;
					end
				end
			endcase
		end

		dec.kmc = RECIP_W'(k_col) * RECIP_60;
		dec.kmb = RECIP_W'(k_bri) * RECIP_60;
	end
endmodule

### sv/lrcf_blend.sv
// One color channel: start + trunc((end-start)*k/60) mod 256, with k/60
// pre-scaled into a reciprocal factor. Depends on lrcf_pkg.
module lrcf_blend (
	input  logic [7:0]                   start_c,
	input  logic [7:0]                   end_c,
	input  logic [lrcf_pkg::RECIP_W-1:0] kmc,
	output logic [7:0]                   chan
);
	import lrcf_pkg::*;

	localparam int unsigned PROD_W = 8 + RECIP_W;

	logic              neg;
	logic [7:0]        mag;
	logic [PROD_W-1:0] prod;
	logic [7:0]        q;

	always_comb begin
		// truncation toward zero: scale the magnitude, then reapply the sign
		neg  = end_c < start_c;
		mag  = neg ? start_c - end_c : end_c - start_c;
		prod = PROD_W'(mag) * PROD_W'(kmc);
		q    = prod[RECIP_SHIFT +: 8];
		chan = neg ? start_c - q : start_c + q;
	end
endmodule

### sv/led_ring_clock_face_renderer_core.sv
// LED ring clock face renderer, top level.
// Depends on lrcf_pkg, the three channel interfaces, lrcf_cfg_regs,
// lrcf_decode and lrcf_blend.
//
// Usage: stream LED indexes with the current time and ambient light on
// pixel_in; one pixel (index echo, brightness, red, green, blue) comes back
// on pixel_out per item, in order. An item with index NUM_LEDS-1 ends a
// frame; the first three frames after reset are green, red and blue fills,
// every later frame is the clock face.
// The user must write the registers on cfg (always ready) only while the
// block is idle; the block does not enforce this. Decode loads the input
// register, then blend and brightness scale load the result register.
// Throughput: one item per cycle while pixel_out does not stall; the three
// channel blends and the brightness scale are one multiply each by a
// reciprocal of 60. When pixel_out stalls, the result register holds and
// the input register fills; pixel_in drops ready once both are occupied,
// nothing is lost. Reset (arst_n low) clears both valid flags, returns to
// the green fill frame and loads max_brightness 31 with all colors 0.
module led_ring_clock_face_renderer_core #(
	parameter int unsigned NUM_LEDS = lrcf_pkg::NUM_LEDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lrcf_in_if.sink    pixel_in,
	lrcf_out_if.source pixel_out,
	lrcf_cfg_if.sink   cfg
);
	import lrcf_pkg::*;

	cfg_regs_t regs;
	mode_t     mode_q;
	dec_t      dec;
	dec_t      item_s1;
	logic      valid_s1;
	logic      out_valid_q;
	logic      out_take;
	logic      in_acc;
	logic      frame_end;

	logic [COLOR_W-1:0] sel_start;
	logic [COLOR_W-1:0] sel_end;
	logic [7:0]         mix_r, mix_g, mix_b;
	logic [8+RECIP_W-1:0] bri_prod;
	logic [7:0]         bri_scaled;
	logic [7:0]         nxt_bri, nxt_r, nxt_g, nxt_b;
	logic [7:0]         out_led_q, out_bri_q, out_r_q, out_g_q, out_b_q;

	lrcf_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lrcf_decode #(
		.NUM_LEDS (NUM_LEDS)
	) u_decode (
		.led_index      (pixel_in.led_index),
		.seconds        (pixel_in.seconds),
		.minutes        (pixel_in.minutes),
		.hours          (pixel_in.hours),
		.light_mv       (pixel_in.light_mv),
		.mode           (mode_q),
		.max_brightness (regs.max_brightness),
		.dec            (dec)
	);

	assign out_take       = !out_valid_q || pixel_out.ready;
	assign pixel_in.ready = !valid_s1 || out_take;
	assign in_acc         = pixel_in.valid && pixel_in.ready;
	assign frame_end      = ({1'b0, pixel_in.led_index} == 9'(NUM_LEDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GREEN;
		end else if (in_acc && frame_end && mode_q != MODE_CLOCK) begin
			mode_q <= mode_t'(mode_q + 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (out_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= dec;
		end
	end

	// color pair for the arc or hour blend
	always_comb begin
		case (item_s1.region)
			RGN_ARC_MIN: begin
				sel_start = regs.min_start;
				sel_end   = regs.min_end;
			end
			RGN_ARC_SEC: begin
				sel_start = regs.sec_start;
				sel_end   = regs.sec_end;
			end
			default: begin
				sel_start = regs.hour_start;
				sel_end   = regs.hour_end;
			end
		endcase
	end

	lrcf_blend u_blend_r (
		.start_c (sel_start[23:16]),
		.end_c   (sel_end[23:16]),
		.kmc     (item_s1.kmc),
		.chan    (mix_r)
	);

	lrcf_blend u_blend_g (
		.start_c (sel_start[15:8]),
		.end_c   (sel_end[15:8]),
		.kmc     (item_s1.kmc),
		.chan    (mix_g)
	);

	lrcf_blend u_blend_b (
		.start_c (sel_start[7:0]),
		.end_c   (sel_end[7:0]),
		.kmc     (item_s1.kmc),
		.chan    (mix_b)
	);

	always_comb begin
		bri_prod   = (8 + RECIP_W)'(item_s1.cap) * (8 + RECIP_W)'(item_s1.kmb);
		bri_scaled = bri_prod[RECIP_SHIFT +: 8];
		nxt_bri = '0;
		nxt_r   = '0;
		nxt_g   = '0;
		nxt_b   = '0;
		case (item_s1.region)
			RGN_FILL_G: begin
				nxt_bri = item_s1.bri;
				nxt_g   = 8'hff;
			end
			RGN_FILL_R: begin
				nxt_bri = item_s1.bri;
				nxt_r   = 8'hff;
			end
			RGN_FILL_B: begin
				nxt_bri = item_s1.bri;
				nxt_b   = 8'hff;
			end
			RGN_ARC_MIN, RGN_ARC_SEC: begin
				nxt_bri = item_s1.bri;
				nxt_r   = mix_r;
				nxt_g   = mix_g;
				nxt_b   = mix_b;
			end
			RGN_HOUR_CUR: begin
				// fading segment never drops below the floor
				nxt_bri = (bri_scaled < BRIGHT_FLOOR) ? BRIGHT_FLOOR : bri_scaled;
				nxt_r   = mix_r;
				nxt_g   = mix_g;
				nxt_b   = mix_b;
			end
			RGN_HOUR_NXT: begin
				nxt_bri = bri_scaled;
				nxt_r   = mix_r;
				nxt_g   = mix_g;
				nxt_b   = mix_b;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && valid_s1) begin
			out_led_q <= item_s1.led;
			out_bri_q <= nxt_bri;
			out_r_q   <= nxt_r;
			out_g_q   <= nxt_g;
			out_b_q   <= nxt_b;
		end
	end

	assign pixel_out.valid         = out_valid_q;
	assign pixel_out.led_out_index = out_led_q;
	assign pixel_out.brightness    = out_bri_q;
	assign pixel_out.red           = out_r_q;
	assign pixel_out.green         = out_g_q;
	assign pixel_out.blue          = out_b_q;

`ifndef SYNTHESIS
	a_clock_mode_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_CLOCK |=> mode_q == MODE_CLOCK)
		else $error("display mode left clock face");

	a_mode_only_at_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && frame_end) |=> $stable(mode_q))
		else $error("display mode moved without a frame end");

	a_stalled_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_take |=> valid_s1 && $stable(item_s1))
		else $error("input register item lost under stall");
`endif
endmodule
